// ===== hw/rtl/rule_redundancy_filter_defines.svh =====
// assertion macros for the rule redundancy filter
// used by rule_redundancy_filter.sv, no other dependencies
`ifndef RULE_REDUNDANCY_FILTER_DEFINES_SVH
`define RULE_REDUNDANCY_FILTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rule filter check failed");

// next-cycle implication, checked out of reset
`define RRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rule filter check failed");

`endif

// ===== hw/rtl/rrf_pkg.sv =====
// shared types and constants of the rule redundancy filter
// no dependencies; used by rrf_ctrl, rrf_datapath and the top level
`default_nettype none

package rrf_pkg;

    // fixed field widths of the stream and config ports
    localparam int DIM_SLOTS      = 5;
    localparam int FIELD_BITS     = 32;
    localparam int PRIO_BITS      = 20;
    localparam int COUNT_BITS     = 9;
    localparam int CFG_BITS       = 64;
    localparam int CFG_IDX_BITS   = 3;
    localparam int IN_TDATA_BITS  = 344;
    localparam int OUT_TDATA_BITS = 32;

    // bit offsets in the request tdata
    localparam int PRIO_LSB = 2 * DIM_SLOTS * FIELD_BITS;

    // defaults of the top-level parameters
    localparam int MAX_KEPT_DEF   = 256;
    localparam int NUM_DIMS_DEF   = 5;
    localparam int RANGE_BITS_DEF = 32;

    // boundary reset value: low 0, high all ones
    localparam logic [CFG_BITS-1:0] BOUNDARY_RST = 64'h0000_0000_FFFF_FFFF;

    // result reason codes
    typedef enum logic [1:0] {
        R_KEPT      = 2'd0,
        R_COVERED   = 2'd1,
        R_SAME_PRIO = 2'd2,
        R_FULL      = 2'd3
    } t_reason;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_busy;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/rrf_ctrl.sv =====
// controller state machine of the rule redundancy filter
// depends on rrf_pkg; drives the commands of rrf_datapath
`default_nettype none

module rrf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_valid,
    output logic                 o_s_ready,
    output logic                 o_m_valid,
    input  wire logic            i_m_ready,
    input  wire rrf_pkg::t_status i_status,
    output rrf_pkg::t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    // output register can take a result this cycle
    assign w_out_free = !r_out_valid || i_m_ready;

    // commands
    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_s_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_FIN) && w_out_free;
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (!i_status.scan_busy) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rrf_datapath.sv =====
// datapath of the rule redundancy filter: boundaries, clipping, kept table,
// scan compare and result register; depends on rrf_pkg
`default_nettype none

module rrf_datapath #(
    parameter int MAX_KEPT   = rrf_pkg::MAX_KEPT_DEF,
    parameter int NUM_DIMS   = rrf_pkg::NUM_DIMS_DEF,
    parameter int RANGE_BITS = rrf_pkg::RANGE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rrf_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [rrf_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  wire logic [rrf_pkg::IN_TDATA_BITS-1:0]   i_s_data,
    input  wire logic                                i_s_last,
    input  wire rrf_pkg::t_cmd                       i_cmd,
    output rrf_pkg::t_status                         o_status,
    output logic [rrf_pkg::OUT_TDATA_BITS-1:0]       o_m_data,
    output logic                                     o_m_last
);

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int WW = 2 * NUM_DIMS * RANGE_BITS;
    localparam int FB = rrf_pkg::FIELD_BITS;
    localparam int PB = rrf_pkg::PRIO_BITS;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEPT);

    // configuration registers
    logic [rrf_pkg::CFG_BITS-1:0] r_bound [rrf_pkg::DIM_SLOTS];

    // current rule
    logic [RANGE_BITS-1:0] r_lo [NUM_DIMS];
    logic [RANGE_BITS-1:0] r_hi [NUM_DIMS];
    logic [RANGE_BITS-1:0] w_lo [NUM_DIMS];
    logic [RANGE_BITS-1:0] w_hi [NUM_DIMS];
    logic [PB-1:0]         r_prio;
    logic                  r_last;

    // kept table and its bookkeeping
    logic [WW-1:0]  r_mem [MAX_KEPT];
    logic [WW-1:0]  r_rd_data;
    logic [WW-1:0]  w_wr_word;
    logic [CW-1:0]  r_count;
    logic [PB-1:0]  r_last_prio;
    logic           r_last_valid;

    // scan state
    logic [CW-1:0]  r_scan_idx;
    logic           r_rd_valid;
    logic           r_hit;
    logic           w_entry_match;
    logic           w_match_now;
    logic           w_issue;

    // commit decision
    logic             w_room;
    logic             w_dup;
    logic             w_store;
    logic [CW-1:0]    w_count_after;
    rrf_pkg::t_reason w_reason;
    logic             w_keep;

    // boundary writes, indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < rrf_pkg::DIM_SLOTS; s++) begin
                r_bound[s] <= rrf_pkg::BOUNDARY_RST;
            end
        end else if (i_cfg_we && (i_cfg_idx < rrf_pkg::CFG_IDX_BITS'(rrf_pkg::DIM_SLOTS))) begin
            r_bound[i_cfg_idx] <= i_cfg_data;
        end
    end

    // clip each range to the node boundary
    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            logic [RANGE_BITS-1:0] rl, rh, bl, bh;
            rl = i_s_data[(2 * d) * FB +: RANGE_BITS];
            rh = i_s_data[(2 * d + 1) * FB +: RANGE_BITS];
            bl = r_bound[d][32 +: RANGE_BITS];
            bh = r_bound[d][0 +: RANGE_BITS];
            w_lo[d] = (rl > bl) ? rl : bl;
            w_hi[d] = (rh < bh) ? rh : bh;
        end
    end

    // capture the clipped rule
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_lo[d] <= w_lo[d];
                r_hi[d] <= w_hi[d];
            end
            r_prio <= i_s_data[rrf_pkg::PRIO_LSB +: PB];
            r_last <= i_s_last;
        end
    end

    // compare the entry read last cycle against the rule
    always_comb begin
        w_entry_match = 1'b1;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (r_rd_data[(2 * d) * RANGE_BITS +: RANGE_BITS] > r_lo[d] ||
                r_rd_data[(2 * d + 1) * RANGE_BITS +: RANGE_BITS] < r_hi[d]) begin
                w_entry_match = 1'b0;
            end
        end
    end

    assign w_match_now = r_rd_valid && w_entry_match;
    assign w_issue     = i_cmd.scan && (r_scan_idx < r_count) && !r_hit && !w_match_now;
    assign o_status.scan_busy = r_rd_valid || ((r_scan_idx < r_count) && !r_hit);

    // scan counter, read pipeline and sticky hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
        end else if (i_cmd.load) begin
            r_scan_idx <= '0;
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_rd_valid <= w_issue;
            if (w_issue) r_scan_idx <= r_scan_idx + CW'(1);
            if (w_match_now) r_hit <= 1'b1;
        end
    end

    // pack the rule into one table word
    always_comb begin
        w_wr_word = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            w_wr_word[(2 * d) * RANGE_BITS +: RANGE_BITS]     = r_lo[d];
            w_wr_word[(2 * d + 1) * RANGE_BITS +: RANGE_BITS] = r_hi[d];
        end
    end

    // table memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_store) r_mem[r_count[AW-1:0]] <= w_wr_word;
        if (w_issue) r_rd_data <= r_mem[r_scan_idx[AW-1:0]];
    end

    // keep, drop and store decision
    always_comb begin
        w_room        = (r_count < MAX_CNT);
        w_dup         = r_last_valid && (r_last_prio == r_prio);
        w_store       = i_cmd.commit && !r_hit && w_room;
        w_count_after = (!r_hit && w_room) ? (r_count + CW'(1)) : r_count;
        if (r_hit) begin
            w_keep   = 1'b0;
            w_reason = rrf_pkg::R_COVERED;
        end else if (w_dup) begin
            w_keep   = 1'b0;
            w_reason = rrf_pkg::R_SAME_PRIO;
        end else begin
            w_keep   = 1'b1;
            w_reason = w_room ? rrf_pkg::R_KEPT : rrf_pkg::R_FULL;
        end
    end

    // table count and previous priority, cleared after the last rule
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_prio  <= '0;
            r_last_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_count      <= '0;
                r_last_prio  <= '0;
                r_last_valid <= 1'b0;
            end else begin
                r_count <= w_count_after;
                if (!r_hit) begin
                    r_last_prio  <= r_prio;
                    r_last_valid <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_m_data <= {rrf_pkg::COUNT_BITS'(w_count_after), r_prio, w_reason, w_keep};
            o_m_last <= r_last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rule_redundancy_filter.sv =====
// Rule redundancy filter: drops classifier rules that a kept rule covers.
// Request channel s_axis: tdata holds ten 32-bit range bounds (dim0 low,
// dim0 high, ... dim4 high) and the 20-bit priority, tlast marks the last
// rule of a batch. Result channel m_axis: tdata holds keep, reason, priority
// and kept count, tlast echoes the last-rule mark. Configuration is a plain
// write port: i_cfg_we, i_cfg_idx (boundary 0..4), i_cfg_data (64 bits).
// One rule is handled at a time. The scan reads one kept table entry per cycle
// through the single read port and stops at the first covering entry. The next
// request can be taken in the cycle after the commit. s_axis_tready drops while
// a rule is being scanned; a finished result waits in the output register while
// the next rule is taken and scanned.
// If the receiver stalls, the result holds and the following rule waits
// at the end of its scan until the output register frees up.
// Reset clears the kept count, the previous priority and sets each boundary
// to the full range; the table memory itself needs no clearing pass.
// After a rule with tlast set, the table and previous priority are cleared.
`default_nettype none
`include "rule_redundancy_filter_defines.svh"

module rule_redundancy_filter #(
    parameter int MAX_KEPT   = rrf_pkg::MAX_KEPT_DEF,
    parameter int NUM_DIMS   = rrf_pkg::NUM_DIMS_DEF,
    parameter int RANGE_BITS = rrf_pkg::RANGE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [rrf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [rrf_pkg::CFG_BITS-1:0]      i_cfg_data,
    // rule requests
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // from bit 0: dim0_low, dim0_high, ... dim4_low, dim4_high (32 each),
    // rule_priority (20), zero pad (4)
    input  wire logic [rrf_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    // results
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // from bit 0: keep (1), reason (2), out_priority (20), kept_count (9)
    output logic [rrf_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
    output logic                                   m_axis_tlast
);

    rrf_pkg::t_cmd    w_cmd;
    rrf_pkg::t_status w_status;

    // controller
    rrf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    // datapath
    rrf_datapath #(
        .MAX_KEPT   (MAX_KEPT),
        .NUM_DIMS   (NUM_DIMS),
        .RANGE_BITS (RANGE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_data   (s_axis_tdata),
        .i_s_last   (s_axis_tlast),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_m_data   (m_axis_tdata),
        .o_m_last   (m_axis_tlast)
    );

    // a new request is never taken in the cycle a result is committed
    `RRF_ASSERT_IMPLY(a_ready_no_commit, i_clk, i_rst_n, s_axis_tready, !w_cmd.commit)
    // a committed result shows on the output in the next cycle
    `RRF_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, w_cmd.commit, m_axis_tvalid)
    // the scan only runs after a request and before the commit
    `RRF_ASSERT_NEXT(a_load_then_scan, i_clk, i_rst_n, w_cmd.load, w_cmd.scan)

endmodule

`default_nettype wire

// ===== test/rrf_checker.sv =====
// result checker for rule_redundancy_filter: watches config, request and result channels
// keeps its own kept-rule table and compares every result; depends on rrf_pkg
`timescale 1ns / 1ps

module rrf_checker #(
    parameter int MAX_KEPT   = rrf_pkg::MAX_KEPT_DEF,
    parameter int NUM_DIMS   = rrf_pkg::NUM_DIMS_DEF,
    parameter int RANGE_BITS = rrf_pkg::RANGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [rrf_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [rrf_pkg::CFG_BITS-1:0]       i_cfg_data,
    // rule requests
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    // from bit 0: dim0_low, dim0_high, ... dim4_high (32 each), rule_priority (20), pad (4)
    input  logic [rrf_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    input  logic                               i_s_tlast,
    // results
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    // from bit 0: keep (1), reason (2), out_priority (20), kept_count (9)
    input  logic [rrf_pkg::OUT_TDATA_BITS-1:0] i_m_tdata,
    input  logic                               i_m_tlast,
    output int                                 o_errors,
    output int                                 o_pending,
    output logic [3:0][31:0]                   o_reason_hits
);

    import rrf_pkg::*;

    localparam logic [FIELD_BITS-1:0] RANGE_MASK = FIELD_BITS'((64'd1 << RANGE_BITS) - 64'd1);

    // one predicted result
    typedef struct packed {
        logic                  keep;
        t_reason               reason;
        logic [PRIO_BITS-1:0]  prio;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } t_verdict;

    // shadow of the boundary registers and the kept table
    logic [CFG_BITS-1:0]   bound_reg [DIM_SLOTS];
    logic [FIELD_BITS-1:0] kept_lo [MAX_KEPT][NUM_DIMS];
    logic [FIELD_BITS-1:0] kept_hi [MAX_KEPT][NUM_DIMS];
    int unsigned           kept_n;
    logic [PRIO_BITS-1:0]  prev_prio;
    logic                  prev_valid;

    t_verdict pending_verdicts [$];
    int       shown;
    int       n_results;

    // clip the rule, scan the table, update it and work out the result
    task automatic judge_rule(input logic [IN_TDATA_BITS-1:0] word, input logic last,
                              output t_verdict v);
        logic [NUM_DIMS-1:0][FIELD_BITS-1:0] lo, hi;
        logic [FIELD_BITS-1:0] rl, rh, bl, bh;
        logic [PRIO_BITS-1:0]  prio;
        logic                  covered, hit, dup, room;
        prio = word[PRIO_LSB +: PRIO_BITS];
        for (int d = 0; d < NUM_DIMS; d++) begin
            rl = word[(2 * d) * FIELD_BITS +: FIELD_BITS] & RANGE_MASK;
            rh = word[(2 * d + 1) * FIELD_BITS +: FIELD_BITS] & RANGE_MASK;
            bl = bound_reg[d][CFG_BITS-1 -: FIELD_BITS] & RANGE_MASK;
            bh = bound_reg[d][FIELD_BITS-1:0] & RANGE_MASK;
            lo[d] = (rl > bl) ? rl : bl;
            hi[d] = (rh < bh) ? rh : bh;
        end
        // first covering entry ends the scan
        covered = 1'b0;
        for (int unsigned e = 0; e < kept_n && e < MAX_KEPT && !covered; e++) begin
            hit = 1'b1;
            for (int d = 0; d < NUM_DIMS; d++)
                if (kept_lo[e][d] > lo[d] || kept_hi[e][d] < hi[d])
                    hit = 1'b0;
            covered = hit;
        end
        v.prio = prio;
        v.last = last;
        if (covered) begin
            v.keep   = 1'b0;
            v.reason = R_COVERED;
        end else begin
            dup  = prev_valid && (prev_prio == prio);
            room = kept_n < MAX_KEPT;
            // same-priority rules still go into the table
            if (room) begin
                for (int d = 0; d < NUM_DIMS; d++) begin
                    kept_lo[kept_n][d] = lo[d];
                    kept_hi[kept_n][d] = hi[d];
                end
                kept_n++;
            end
            prev_prio  = prio;
            prev_valid = 1'b1;
            if (dup) begin
                v.keep   = 1'b0;
                v.reason = R_SAME_PRIO;
            end else begin
                v.keep   = 1'b1;
                v.reason = room ? R_KEPT : R_FULL;
            end
        end
        v.count = COUNT_BITS'(kept_n);
        // end of batch clears the table
        if (last) begin
            kept_n     = 0;
            prev_prio  = '0;
            prev_valid = 1'b0;
        end
    endtask

    // compare results first, then take config and new requests
    always @(posedge i_clk) begin
        t_verdict want, got;
        if (!i_rst_n) begin
            for (int d = 0; d < DIM_SLOTS; d++)
                bound_reg[d] = BOUNDARY_RST;
            kept_n     = 0;
            prev_prio  = '0;
            prev_valid = 1'b0;
            pending_verdicts.delete();
            shown         = 0;
            n_results     = 0;
            o_errors      = 0;
            o_pending     = 0;
            o_reason_hits = '0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.keep   = i_m_tdata[0];
                got.reason = t_reason'(i_m_tdata[2:1]);
                got.prio   = i_m_tdata[3 +: PRIO_BITS];
                got.count  = i_m_tdata[3 + PRIO_BITS +: COUNT_BITS];
                got.last   = i_m_tlast;
                n_results++;
                o_reason_hits[got.reason] = o_reason_hits[got.reason] + 1;
                if (pending_verdicts.size() == 0) begin
                    o_errors++;
                    if (shown < 10) begin
                        shown++;
                        $display("result %0d arrived with no rule waiting: keep %0b reason %0d",
                                 n_results, got.keep, got.reason);
                    end
                end else begin
                    want = pending_verdicts.pop_front();
                    if (want != got) begin
                        o_errors++;
                        if (shown < 10) begin
                            shown++;
                            $display({"result %0d expected keep %0b reason %0d prio %h ",
                                      "count %0d last %0b"},
                                     n_results, want.keep, want.reason, want.prio, want.count,
                                     want.last);
                            $display({"result %0d actual   keep %0b reason %0d prio %h ",
                                      "count %0d last %0b"},
                                     n_results, got.keep, got.reason, got.prio, got.count,
                                     got.last);
                        end
                    end
                end
            end
            if (i_cfg_we && i_cfg_idx < DIM_SLOTS)
                bound_reg[i_cfg_idx] = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                judge_rule(i_s_tdata, i_s_tlast, want);
                pending_verdicts.insert(pending_verdicts.size(), want);
            end
            o_pending = pending_verdicts.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// testbench top for rule_redundancy_filter: clock, reset, rule and config stimulus, verdict
// depends on rrf_pkg, rule_redundancy_filter and rrf_checker
`timescale 1ns / 1ps

module tb;

    import rrf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 300;
    localparam int          PHASES         = 6;
    localparam int          PHASE_RULES    = 220;
    localparam int          FILL_RULES     = MAX_KEPT_DEF;
    localparam int          FILL_EXTRA     = 24;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_BOUND0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE  = 3'd7;

    // how a phase sets the node boundaries
    typedef enum int {
        BND_RESET,
        BND_RANDOM,
        BND_WINDOW,
        BND_EXTREME
    } t_bound_mode;

    typedef struct packed {
        logic [DIM_SLOTS-1:0][FIELD_BITS-1:0] lo;
        logic [DIM_SLOTS-1:0][FIELD_BITS-1:0] hi;
        logic [PRIO_BITS-1:0]                 prio;
        logic                                 last;
    } t_rule;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_idx = '0;
    logic [CFG_BITS-1:0]       cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      m_axis_tlast;

    int               errors;
    int               pending;
    logic [3:0][31:0] reason_hits;

    int          idle_cycles = 0;
    int          rx_cycle = 0;
    int          rx_hold = 0;
    int          burst_left = 0;
    int          batch_left = 0;
    int          rules_sent = 0;
    int          settings_used = 0;
    logic [PRIO_BITS-1:0] prio_cursor = '0;
    t_rule       batch_hist [$];

    rule_redundancy_filter i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rrf_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tlast     (m_axis_tlast),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_reason_hits (reason_hits)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side stalls: the mode steps with a free-running cycle counter
    always @(negedge clk) begin
        rx_cycle++;
        case (rx_cycle[11:10])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(3, 0) != 0);
            2'd2: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(7, 0) == 0)
                        rx_hold = $urandom_range(12, 1);
                end
            end
            default: m_axis_tready <= ($urandom_range(3, 0) == 0);
        endcase
    end

    // no request or result accepted for too long
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one rule request, with burst gaps on the way in
    task automatic send_rule(input t_rule r);
        logic [IN_TDATA_BITS-1:0] word;
        int gap;
        word = '0;
        for (int d = 0; d < DIM_SLOTS; d++) begin
            word[(2 * d) * FIELD_BITS +: FIELD_BITS]     = r.lo[d];
            word[(2 * d + 1) * FIELD_BITS +: FIELD_BITS] = r.hi[d];
        end
        word[PRIO_LSB +: PRIO_BITS] = r.prio;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 20)
                                                     : $urandom_range(8, 1);
            gap = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(12, 1);
            repeat (gap) begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= r.last;
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
        rules_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // rewrite all five boundaries once the block is idle
    task automatic set_boundaries(input t_bound_mode mode);
        logic [FIELD_BITS-1:0] lo, hi;
        wait_idle();
        for (int d = 0; d < DIM_SLOTS; d++) begin
            case (mode)
                BND_RESET: begin
                    lo = '0;
                    hi = '1;
                end
                BND_RANDOM: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                BND_WINDOW: begin
                    lo = $urandom_range(32'h4000_0000, 0);
                    hi = $urandom_range(32'hFFFF_FFFF, 32'hC000_0000);
                end
                default: begin
                    case (d)
                        0: begin lo = '0; hi = '0; end
                        1: begin lo = '1; hi = '0; end
                        2: begin lo = '1; hi = '1; end
                        3: begin lo = '0; hi = '1; end
                        default: begin lo = 32'h0000_1000; hi = 32'h0000_2000; end
                    endcase
                end
            endcase
            cfg_write(CFG_IDX_BITS'(d), {lo, hi});
        end
        settings_used++;
    endtask

    function automatic t_rule flat_rule(input logic [FIELD_BITS-1:0] lo, hi,
                                        input logic [PRIO_BITS-1:0] prio, input logic last);
        t_rule r;
        for (int d = 0; d < DIM_SLOTS; d++) begin
            r.lo[d] = lo;
            r.hi[d] = hi;
        end
        r.prio = prio;
        r.last = last;
        return r;
    endfunction

    function automatic t_rule noise_rule(input logic [PRIO_BITS-1:0] prio, input logic last);
        t_rule r;
        for (int d = 0; d < DIM_SLOTS; d++) begin
            r.lo[d] = $urandom;
            r.hi[d] = $urandom;
        end
        r.prio = prio;
        r.last = last;
        return r;
    endfunction

    // random rule of the current batch: wide rules, sub-ranges of earlier ones,
    // narrow fresh ones and plain noise
    task automatic gen_rule(output t_rule r);
        t_rule src;
        int    kind;
        if (batch_left == 0)
            batch_left = ($urandom_range(7, 0) == 0) ? $urandom_range(120, 40)
                                                     : $urandom_range(40, 1);
        kind = $urandom_range(9, 0);
        if (kind >= 2 && kind <= 4 && batch_hist.size() == 0)
            kind = 5;
        if (kind <= 1) begin
            for (int d = 0; d < DIM_SLOTS; d++) begin
                r.lo[d] = $urandom_range(32'h00FF_FFFF, 0);
                r.hi[d] = 32'hFFFF_FFFF - $urandom_range(32'h00FF_FFFF, 0);
            end
        end else if (kind <= 4) begin
            src = batch_hist[$urandom_range(batch_hist.size() - 1, 0)];
            for (int d = 0; d < DIM_SLOTS; d++) begin
                if (src.lo[d] <= src.hi[d] && kind != 4) begin
                    r.lo[d] = $urandom_range(src.hi[d], src.lo[d]);
                    r.hi[d] = $urandom_range(src.hi[d], r.lo[d]);
                end else begin
                    r.lo[d] = src.lo[d];
                    r.hi[d] = src.hi[d];
                end
            end
        end else if (kind <= 7) begin
            for (int d = 0; d < DIM_SLOTS; d++) begin
                r.lo[d] = $urandom;
                r.hi[d] = r.lo[d] + $urandom_range(32'h000F_FFFF, 0);
            end
        end else begin
            r = noise_rule('0, 1'b0);
        end
        // mostly rising priorities with repeats, now and then a jump
        if ($urandom_range(15, 0) == 0)
            prio_cursor = PRIO_BITS'($urandom);
        else if ($urandom_range(3, 0) != 0)
            prio_cursor = PRIO_BITS'(prio_cursor + 1 + $urandom_range(3, 0));
        r.prio = prio_cursor;
        r.last = (batch_left == 1);
        batch_left--;
        if (r.last)
            batch_hist.delete();
        else
            batch_hist.insert(batch_hist.size(), r);
    endtask

    initial begin
        t_rule r, first_fill;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        settings_used = 1;

        // directed batch at reset boundaries: kept, empty range covered, same priority
        send_rule(flat_rule(32'h5555_5555, 32'hAAAA_AAAA, 20'h00000, 1'b0));
        send_rule(flat_rule(32'hAAAA_AAAA, 32'h5555_5555, 20'h00001, 1'b0));
        send_rule(flat_rule(32'h0000_0000, 32'h0000_0000, 20'h00001, 1'b0));
        send_rule(flat_rule(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h00001, 1'b0));
        send_rule(flat_rule(32'h0000_0000, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1));

        // extreme boundaries, then one changed in the middle of the batch
        set_boundaries(BND_EXTREME);
        send_rule(noise_rule(20'h00010, 1'b0));
        send_rule(noise_rule(20'h00011, 1'b0));
        send_rule(noise_rule(20'h00011, 1'b0));
        wait_idle();
        cfg_write(CFG_IDX_BOUND0, BOUNDARY_RST);
        cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
        send_rule(flat_rule(32'h0000_0000, 32'hFFFF_FFFF, 20'h00012, 1'b0));
        send_rule(flat_rule(32'h0000_0000, 32'hFFFF_FFFF, 20'h00012, 1'b1));

        // fill the table with rules that are distinct points in dim 0, then overflow it
        set_boundaries(BND_RESET);
        prio_cursor = 20'h00100;
        for (int k = 0; k < FILL_RULES + FILL_EXTRA; k++) begin
            r = noise_rule(prio_cursor, 1'b0);
            if (k < FILL_RULES) begin
                r.lo[0] = FIELD_BITS'(k * 3 + 1);
                r.hi[0] = FIELD_BITS'(k * 3 + 1);
                if (k == 0)
                    first_fill = r;
                prio_cursor++;
            end else begin
                case (k % 3)
                    0: begin
                        prio_cursor++;
                        r.lo[0] = 32'h8000_0000 + k;
                        r.hi[0] = 32'h8000_0000 + k;
                        r.prio  = prio_cursor;
                    end
                    1: r = first_fill;
                    default: begin
                        r.lo[0] = 32'h9000_0000 + k;
                        r.hi[0] = 32'h9000_0000 + k;
                        r.prio  = prio_cursor;
                    end
                endcase
            end
            r.last = (k == FILL_RULES + FILL_EXTRA - 1);
            send_rule(r);
        end

        // random phases; batches run across phase changes
        for (int p = 0; p < PHASES; p++) begin
            set_boundaries(t_bound_mode'(p % 4));
            for (int i = 0; i < PHASE_RULES; i++) begin
                gen_rule(r);
                send_rule(r);
                if ($urandom_range(199, 0) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display({"sent %0d rules over %0d boundary settings, ",
                  "incl. a full table and mid-batch changes"},
                 rules_sent, settings_used);
        $display("results: %0d kept, %0d covered, %0d same priority, %0d kept with table full",
                 reason_hits[R_KEPT], reason_hits[R_COVERED], reason_hits[R_SAME_PRIO],
                 reason_hits[R_FULL]);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rrf_pkg.sv
hw/rtl/rrf_ctrl.sv
hw/rtl/rrf_datapath.sv
hw/rtl/rule_redundancy_filter.sv
test/rrf_checker.sv
test/tb.sv
